// ----- rtl/core/bmpd_pkg.sv -----
`default_nettype none
package bmpd_pkg;

  localparam int unsigned MaxStep    = 4;
  localparam int unsigned StoreDepth = MaxStep * MaxStep;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned CoordW     = 16;
  localparam int unsigned DepthW     = 15;
  localparam int unsigned StepW      = 3;
  localparam int unsigned CfgW       = 15;

  localparam logic [1:0] RegBlockStep = 2'd0;
  localparam logic [1:0] RegMinDepth  = 2'd1;
  localparam logic [1:0] RegMaxDepth  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture point into the input register
    logic insert;  // insert the captured point into the sorted stores
    logic open;    // captured point opens a block
    logic emit;    // load the result register
  } bmpd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pt_valid;  // captured point passes the filter and fits
    logic pt_end;
  } bmpd_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/bmpd_ctrl.sv -----
`default_nettype none
module bmpd_ctrl
  import bmpd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire bmpd_sts_t sts_i,
  output bmpd_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWork,
    StFirst
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   open_q, open_d;
  logic   accept;

  // Take a new point only when idle, unless a result is waiting and would be overwritten.
  assign in_stall_o  = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    open_d      = open_q;
    cmd_o       = '0;
    cmd_o.load  = accept;
    case (state_q)
      StIdle: begin
        if (accept) state_d = open_q ? StWork : StFirst;
      end
      StFirst, StWork: begin
        cmd_o.open   = (state_q == StFirst);
        cmd_o.insert = sts_i.pt_valid;
        open_d       = 1'b1;
        if (sts_i.pt_end) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          open_d      = 1'b0;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      open_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      open_q      <= open_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bmpd_datapath.sv -----
`default_nettype none
module bmpd_datapath
  import bmpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bmpd_cmd_t                cmd_i,
  output bmpd_sts_t                     sts_o,
  input  wire logic [StepW-1:0]         block_step_i,
  input  wire logic [DepthW-1:0]        min_depth_i,
  input  wire logic [DepthW-1:0]        max_depth_i,
  input  wire logic signed [CoordW-1:0] coord_x_i,
  input  wire logic signed [CoordW-1:0] coord_y_i,
  input  wire logic signed [CoordW-1:0] coord_z_i,
  input  wire logic                     is_finite_i,
  input  wire logic                     block_end_i,
  output logic signed [CoordW-1:0]      rep_x_o,
  output logic signed [CoordW-1:0]      rep_y_o,
  output logic signed [CoordW-1:0]      rep_z_o,
  output logic                          rep_finite_o,
  output logic                          passed_through_o
);

  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic                     pfin_q, pend_q;
  logic signed [CoordW-1:0] xs_q [StoreDepth];
  logic signed [CoordW-1:0] ys_q [StoreDepth];
  logic signed [CoordW-1:0] zs_q [StoreDepth];
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_base;
  logic signed [CoordW-1:0] fx_q, fy_q, fz_q;
  logic                     ffin_q;
  logic [StepW-1:0]         step;
  logic [CntW-1:0]          cap;
  logic                     in_range;
  logic [IdxW-1:0]          mid;
  logic signed [CoordW-1:0] fx, fy, fz;
  logic                     ffin;

  always_comb begin
    step = block_step_i;
    if (step == '0) step = StepW'(1);
    if (step > StepW'(MaxStep)) step = StepW'(MaxStep);
    cap = CntW'(step) * CntW'(step);
  end

  assign in_range = pfin_q
                 && ($signed({1'b0, min_depth_i}) < pz_q)
                 && (pz_q < $signed({1'b0, max_depth_i}));
  assign cnt_base = cmd_i.open ? '0 : cnt_q;
  assign sts_o.pt_valid = in_range && (cnt_base < cap);
  assign sts_o.pt_end   = pend_q;
  assign cnt_d          = cnt_base + CntW'(cmd_i.insert);

  // First point of the block, taken straight from the capture register while it opens the block.
  assign fx   = cmd_i.open ? px_q : fx_q;
  assign fy   = cmd_i.open ? py_q : fy_q;
  assign fz   = cmd_i.open ? pz_q : fz_q;
  assign ffin = cmd_i.open ? pfin_q : ffin_q;
  assign mid  = IdxW'(cnt_d >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.emit || cmd_i.insert || cmd_i.open) begin
      if (!cmd_i.load) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= coord_x_i;
      py_q   <= coord_y_i;
      pz_q   <= coord_z_i;
      pfin_q <= is_finite_i;
      pend_q <= block_end_i;
    end
    if (cmd_i.open) begin
      fx_q   <= px_q;
      fy_q   <= py_q;
      fz_q   <= pz_q;
      ffin_q <= pfin_q;
    end
    // Sorted insert: each cell shifts up when its left neighbor is larger.
    if (cmd_i.insert) begin
      for (int i = 0; i < StoreDepth; i++) begin
        if (CntW'(i) <= cnt_base) begin
          if (i > 0 && xs_q[(i > 0) ? i - 1 : 0] > px_q) xs_q[i] <= xs_q[(i > 0) ? i - 1 : 0];
          else if (CntW'(i) == cnt_base || xs_q[i] > px_q) xs_q[i] <= px_q;
          if (i > 0 && ys_q[(i > 0) ? i - 1 : 0] > py_q) ys_q[i] <= ys_q[(i > 0) ? i - 1 : 0];
          else if (CntW'(i) == cnt_base || ys_q[i] > py_q) ys_q[i] <= py_q;
          if (i > 0 && zs_q[(i > 0) ? i - 1 : 0] > pz_q) zs_q[i] <= zs_q[(i > 0) ? i - 1 : 0];
          else if (CntW'(i) == cnt_base || zs_q[i] > pz_q) zs_q[i] <= pz_q;
        end
      end
    end
  end

  // Median after this insert: compute from pre-insert store at emit time.
  logic signed [CoordW-1:0] mx, my, mz;
  always_comb begin
    mx = xs_q[mid];
    my = ys_q[mid];
    mz = zs_q[mid];
    if (cmd_i.insert) begin
      // Element at mid in the post-insert order.
      if (mid == IdxW'(0)) begin
        if (xs_q[0] > px_q || cnt_base == '0) mx = px_q;
        if (ys_q[0] > py_q || cnt_base == '0) my = py_q;
        if (zs_q[0] > pz_q || cnt_base == '0) mz = pz_q;
      end else begin
        if (CntW'(mid) == cnt_base || xs_q[mid] > px_q)
          mx = (xs_q[mid - IdxW'(1)] > px_q) ? xs_q[mid - IdxW'(1)] : px_q;
        if (CntW'(mid) == cnt_base || ys_q[mid] > py_q)
          my = (ys_q[mid - IdxW'(1)] > py_q) ? ys_q[mid - IdxW'(1)] : py_q;
        if (CntW'(mid) == cnt_base || zs_q[mid] > pz_q)
          mz = (zs_q[mid - IdxW'(1)] > pz_q) ? zs_q[mid - IdxW'(1)] : pz_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cnt_d != '0) begin
        rep_x_o <= mx; rep_y_o <= my; rep_z_o <= mz;
        rep_finite_o <= 1'b1; passed_through_o <= 1'b0;
      end else begin
        rep_x_o <= fx; rep_y_o <= fy; rep_z_o <= fz;
        rep_finite_o <= ffin; passed_through_o <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/block_median_point_downsampler.sv -----
// A block's result is valid once its last point has passed the capture register and then the result register.
// A new point is taken only after the previous one is done: capture, then sorted insert in the cell row.
// A waiting result stalls input only while out_stall_i holds it.
// Reset (async, active low) clears control and sets block_step 2, depths 300/5000.
`default_nettype none
module block_median_point_downsampler
  import bmpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [CfgW-1:0]          cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [CoordW-1:0] coord_x_i,
  input  wire logic signed [CoordW-1:0] coord_y_i,
  input  wire logic signed [CoordW-1:0] coord_z_i,
  input  wire logic                     is_finite_i,
  input  wire logic                     block_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [CoordW-1:0]      rep_x_o,
  output logic signed [CoordW-1:0]      rep_y_o,
  output logic signed [CoordW-1:0]      rep_z_o,
  output logic                          rep_finite_o,
  output logic                          passed_through_o
);

  logic [StepW-1:0]  step_q;
  logic [DepthW-1:0] min_q, max_q;
  bmpd_cmd_t         cmd;
  bmpd_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepW'(2);
      min_q  <= DepthW'(300);
      max_q  <= DepthW'(5000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBlockStep: step_q <= cfg_data_i[StepW-1:0];
        RegMinDepth:  min_q  <= cfg_data_i[DepthW-1:0];
        RegMaxDepth:  max_q  <= cfg_data_i[DepthW-1:0];
        default: ;
      endcase
    end
  end

  bmpd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  bmpd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .block_step_i(step_q), .min_depth_i(min_q), .max_depth_i(max_q),
    .coord_x_i, .coord_y_i, .coord_z_i, .is_finite_i, .block_end_i,
    .rep_x_o, .rep_y_o, .rep_z_o, .rep_finite_o, .passed_through_o
  );

  a_emit_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.pt_end) else $error("result without block end");
  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !(cmd.insert || cmd.emit)) else $error("capture during work");
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o) else $error("result lost");

endmodule
`default_nettype wire
